### hw/rtl/phc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package phc_pkg;

    // Accumulator and term widths
    localparam int ACC_W  = 32;
    localparam int TERM_W = 32;
    localparam int TEMP_W = 16;
    localparam int MARG_W = 12;
    localparam int GAIN_W = 16;
    localparam int VALVE_W = 17;
    localparam int ERR_W  = TEMP_W + 1;
    localparam int LIM_W  = TEMP_W + 2;
    localparam int PROD_W = 2 * ERR_W;
    localparam int SUM_W  = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_MARGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_MARGIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_STEP_GAIN = 3'd4;

    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [VALVE_W-1:0] FULL_SCALE = 17'h10000;
    localparam acc_t FULL_SCALE_ACC = acc_t'({1'b0, FULL_SCALE});

    // Live configuration
    typedef struct packed {
        logic signed [TEMP_W-1:0] target_temp;
        logic [MARG_W-1:0]        on_margin;
        logic [MARG_W-1:0]        off_margin;
        logic [GAIN_W-1:0]        kp_gain;
        logic [GAIN_W-1:0]        ki_step_gain;
    } cfg_t;

    // Item between the gate stage and the integrator stage
    typedef struct packed {
        logic  active;
        logic  clear;
        logic  err_pos;
        logic  err_neg;
        acc_t  pterm;
        prod_t ki_prod;
    } mid_t;

    // Saturate a wide sum into the signed accumulator range
    function automatic acc_t sat_acc(input sum_t v);
        if (&v[SUM_W-1:ACC_W-1] || ~|v[SUM_W-1:ACC_W-1]) begin
            return v[ACC_W-1:0];
        end else if (v[SUM_W-1]) begin
            return ACC_MIN;
        end else begin
            return ACC_MAX;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/phc_gate.sv
`timescale 1ns / 1ps
`default_nettype none

module phc_gate (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire phc_pkg::cfg_t                  cfg,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           heating_enabled,
    input  wire logic signed [phc_pkg::TEMP_W-1:0] home_temp,
    output logic                                mid_valid,
    input  wire logic                           mid_ready,
    output phc_pkg::mid_t                       mid
);
    import phc_pkg::*;

    logic                     in_valid_reg;
    logic                     en_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     regulating_reg;
    logic                     regulating_next;
    logic                     mid_valid_reg;
    mid_t                     mid_reg;
    mid_t                     mid_next;
    logic                     mid_load;

    logic signed [LIM_W-1:0]  temp_ext;
    logic signed [LIM_W-1:0]  on_lim;
    logic signed [LIM_W-1:0]  off_lim;
    logic                     turn_on;
    logic                     turn_off;
    logic signed [ERR_W-1:0]  err;
    prod_t                    kp_prod;

    assign mid_load  = in_valid_reg && (!mid_valid_reg || mid_ready);
    assign in_ready  = !in_valid_reg || mid_load;
    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

    // Hysteresis thresholds and error
    always_comb begin
        temp_ext = LIM_W'(temp_reg);
        on_lim   = LIM_W'(cfg.target_temp) + $signed({{(LIM_W-MARG_W){1'b0}}, cfg.on_margin});
        off_lim  = LIM_W'(cfg.target_temp) + $signed({{(LIM_W-MARG_W){1'b0}}, cfg.off_margin});
        turn_off = en_reg && regulating_reg && (temp_ext > off_lim);
        turn_on  = en_reg && !regulating_reg && (temp_ext < on_lim);
        regulating_next = en_reg && (turn_on || (regulating_reg && !turn_off));
        err      = ERR_W'(cfg.target_temp) - ERR_W'(temp_reg);
        kp_prod  = $signed({1'b0, cfg.kp_gain}) * err;

        mid_next.active  = regulating_next;
        mid_next.clear   = !en_reg || turn_off;
        mid_next.err_pos = !err[ERR_W-1] && (err != '0);
        mid_next.err_neg = err[ERR_W-1];
        mid_next.pterm   = sat_acc(SUM_W'(kp_prod));
        mid_next.ki_prod = $signed({1'b0, cfg.ki_step_gain}) * err;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            in_valid_reg <= 1'b1;
        end else if (mid_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            en_reg   <= heating_enabled;
            temp_reg <= home_temp;
        end
    end

    // Advance hysteresis state and the product register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regulating_reg <= 1'b0;
            mid_valid_reg  <= 1'b0;
        end else begin
            if (mid_load) begin
                regulating_reg <= regulating_next;
                mid_valid_reg  <= 1'b1;
            end else if (mid_ready) begin
                mid_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_load) begin
            mid_reg <= mid_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/phc_integ.sv
`timescale 1ns / 1ps
`default_nettype none

module phc_integ (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            mid_valid,
    output logic                                 mid_ready,
    input  wire phc_pkg::mid_t                   mid,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output logic [phc_pkg::VALVE_W-1:0]          valve_target,
    output logic                                 control_active,
    output logic signed [phc_pkg::TERM_W-1:0]    proportional_term,
    output logic signed [phc_pkg::TERM_W-1:0]    integral_term
);
    import phc_pkg::*;

    acc_t                      integrator_reg;
    acc_t                      integrator_next;
    logic                      res_valid_reg;
    logic [VALVE_W-1:0]        valve_reg;
    logic                      active_reg;
    logic signed [TERM_W-1:0]  pterm_reg;
    logic signed [TERM_W-1:0]  iterm_reg;
    logic                      res_load;

    acc_t                      int_step;
    acc_t                      out_sum;
    logic                      clamp_high;
    logic                      clamp_low;
    logic                      restore;
    logic [VALVE_W-1:0]        valve_next;

    assign mid_ready = !res_valid_reg || res_ready;
    assign res_load  = mid_valid && mid_ready;

    assign res_valid         = res_valid_reg;
    assign valve_target      = valve_reg;
    assign control_active    = active_reg;
    assign proportional_term = pterm_reg;
    assign integral_term     = iterm_reg;

    // Integrator step, output clamp and anti-windup
    always_comb begin
        int_step   = sat_acc(SUM_W'(integrator_reg) + SUM_W'(mid.ki_prod));
        out_sum    = sat_acc(SUM_W'(int_step) + SUM_W'(mid.pterm));
        clamp_high = out_sum > FULL_SCALE_ACC;
        clamp_low  = out_sum[ACC_W-1];
        restore    = (clamp_high && mid.err_pos) || (clamp_low && mid.err_neg);
        if (clamp_high) begin
            valve_next = FULL_SCALE;
        end else if (clamp_low) begin
            valve_next = '0;
        end else begin
            valve_next = out_sum[VALVE_W-1:0];
        end
        if (mid.clear) begin
            integrator_next = '0;
        end else if (mid.active && !restore) begin
            integrator_next = int_step;
        end else begin
            integrator_next = integrator_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integrator_reg <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (res_load) begin
                integrator_reg <= integrator_next;
                res_valid_reg  <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg  <= 1'b0;
            end
        end
    end

    // Result register; terms read zero while control is off
    always_ff @(posedge aclk) begin
        if (res_load) begin
            active_reg <= mid.active;
            if (mid.active) begin
                valve_reg <= valve_next;
                pterm_reg <= TERM_W'(mid.pterm);
                iterm_reg <= TERM_W'(int_step);
            end else begin
                valve_reg <= '0;
                pterm_reg <= '0;
                iterm_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pi_heating_controller_hysteresis_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    heating_enabled, home_temp
// m_        out        m_valid/m_ready    valve_target, control_active,
//                                         proportional_term, integral_term
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One item per cycle sustained while m_ready stays high; each item passes in
// turn through the input register, product register and result register.
// The rate is set by the integrator feedback, closed within the
// result stage. Reset is synchronous, active low, and restores the default
// configuration, control off and a zero integrator. A stall on m_ready
// fills the three stages, then drops s_ready.
module pi_heating_controller_hysteresis_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [phc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [phc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_heating_enabled,
    input  wire logic signed [phc_pkg::TEMP_W-1:0] s_home_temp,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [phc_pkg::VALVE_W-1:0]            m_valve_target,
    output logic                                   m_control_active,
    output logic signed [phc_pkg::TERM_W-1:0]      m_proportional_term,
    output logic signed [phc_pkg::TERM_W-1:0]      m_integral_term
);
    import phc_pkg::*;

    cfg_t cfg_reg;
    logic mid_valid;
    logic mid_ready;
    mid_t mid;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_temp  <= 16'sd5120;
            cfg_reg.on_margin    <= 12'd51;
            cfg_reg.off_margin   <= 12'd256;
            cfg_reg.kp_gain      <= 16'd256;
            cfg_reg.ki_step_gain <= 16'd77;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TARGET_TEMP:  cfg_reg.target_temp  <= $signed(cfg_wdata[TEMP_W-1:0]);
                CFG_ON_MARGIN:    cfg_reg.on_margin    <= cfg_wdata[MARG_W-1:0];
                CFG_OFF_MARGIN:   cfg_reg.off_margin   <= cfg_wdata[MARG_W-1:0];
                CFG_KP_GAIN:      cfg_reg.kp_gain      <= cfg_wdata[GAIN_W-1:0];
                CFG_KI_STEP_GAIN: cfg_reg.ki_step_gain <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    phc_gate u_gate (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .heating_enabled (s_heating_enabled),
        .home_temp       (s_home_temp),
        .mid_valid       (mid_valid),
        .mid_ready       (mid_ready),
        .mid             (mid)
    );

    phc_integ u_integ (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .mid_valid         (mid_valid),
        .mid_ready         (mid_ready),
        .mid               (mid),
        .res_valid         (m_valid),
        .res_ready         (m_ready),
        .valve_target      (m_valve_target),
        .control_active    (m_control_active),
        .proportional_term (m_proportional_term),
        .integral_term     (m_integral_term)
    );

    // Input side only stalls when every stage holds an item
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && mid_valid))
        else $error("input stalled with a free stage");

    // Clearing the integrator always comes with control off
    a_clear_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_valid && mid.clear) |-> !mid.active)
        else $error("integrator clear while regulating");

    // Inactive results carry a closed valve and zero terms
    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_control_active) |->
            (m_valve_target == '0 && m_proportional_term == '0 &&
             m_integral_term == '0))
        else $error("nonzero result while control off");

    // Valve never exceeds full scale
    a_valve_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_valve_target <= FULL_SCALE))
        else $error("valve above full scale");

endmodule

`default_nettype wire

### verif/tb_pi_heating_controller_hysteresis_core.sv
`timescale 1ns / 1ps

module tb_pi_heating_controller_hysteresis_core;
    import phc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 160;

    localparam cfg_t RESET_SETTINGS = '{
        target_temp:  16'sd5120,
        on_margin:    12'd51,
        off_margin:   12'd256,
        kp_gain:      16'd256,
        ki_step_gain: 16'd77
    };

    typedef struct packed {
        logic [VALVE_W-1:0]       valve_target;
        logic                     control_active;
        logic signed [TERM_W-1:0] proportional_term;
        logic signed [TERM_W-1:0] integral_term;
    } valve_result_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_heating_enabled = 1'b0;
    logic signed [TEMP_W-1:0]   s_home_temp = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [VALVE_W-1:0]         m_valve_target;
    logic                       m_control_active;
    logic signed [TERM_W-1:0]   m_proportional_term;
    logic signed [TERM_W-1:0]   m_integral_term;

    // Controller copy: settings, hysteresis state and integrator
    cfg_t          settings = RESET_SETTINGS;
    logic          regulating_now = 1'b0;
    longint        integrator_acc = 0;
    valve_result_t pending_valve_results[$];

    int          fail_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    int unsigned hold_token = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;

    pi_heating_controller_hysteresis_core dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_heating_enabled   (s_heating_enabled),
        .s_home_temp         (s_home_temp),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_valve_target      (m_valve_target),
        .m_control_active    (m_control_active),
        .m_proportional_term (m_proportional_term),
        .m_integral_term     (m_integral_term)
    );

    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint clip_to_acc(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (ACC_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advance the controller by one sample and queue the valve result
    task automatic compute_valve_response(input logic enabled,
                                          input logic signed [TEMP_W-1:0] temp);
        valve_result_t r;
        longint t;
        longint target;
        longint err;
        longint prior;
        longint pterm;
        longint iterm;
        longint sum;
        longint valve;
        t = temp;
        target = $signed(settings.target_temp);
        pterm = 0;
        iterm = 0;
        valve = 0;
        if (!enabled) begin
            regulating_now = 1'b0;
            integrator_acc = 0;
        end else begin
            // Hysteresis gate; switching off clears the integrator
            if (regulating_now && t > target + longint'(settings.off_margin)) begin
                regulating_now = 1'b0;
                integrator_acc = 0;
            end else if (!regulating_now && t < target + longint'(settings.on_margin)) begin
                regulating_now = 1'b1;
            end
            if (regulating_now) begin
                err = target - t;
                prior = integrator_acc;
                pterm = clip_to_acc(longint'(settings.kp_gain) * err);
                integrator_acc = clip_to_acc(integrator_acc
                                             + longint'(settings.ki_step_gain) * err);
                iterm = integrator_acc;
                sum = clip_to_acc(pterm + integrator_acc);
                // Clamp, undoing the step when the clamp and the error agree
                if (sum > longint'(FULL_SCALE)) begin
                    valve = longint'(FULL_SCALE);
                    if (err > 0) integrator_acc = prior;
                end else if (sum < 0) begin
                    valve = 0;
                    if (err < 0) integrator_acc = prior;
                end else begin
                    valve = sum;
                end
            end
        end
        r.valve_target = VALVE_W'(valve);
        r.control_active = regulating_now;
        r.proportional_term = TERM_W'(pterm);
        r.integral_term = TERM_W'(iterm);
        pending_valve_results.push_back(r);
    endtask

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("MISMATCH: %s", msg);
    endtask

    // Check each accepted result item against the oldest expectation
    always @(negedge aclk) begin
        valve_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_valve_results.size() == 0) begin
                flag_failure("result item with no expectation");
            end else begin
                want = pending_valve_results.pop_front();
                if (m_valve_target !== want.valve_target)
                    flag_failure($sformatf("valve_target: expected %0d, got %0d",
                                           want.valve_target, m_valve_target));
                if (m_control_active !== want.control_active)
                    flag_failure($sformatf("control_active: expected %0b, got %0b",
                                           want.control_active, m_control_active));
                if (m_proportional_term !== want.proportional_term)
                    flag_failure($sformatf("proportional_term: expected %0d, got %0d",
                                           $signed(want.proportional_term),
                                           m_proportional_term));
                if (m_integral_term !== want.integral_term)
                    flag_failure($sformatf("integral_term: expected %0d, got %0d",
                                           $signed(want.integral_term), m_integral_term));
            end
        end
    end

    // Stall the result channel: long hold-off on request, else a randomly chosen pattern
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (rx_mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(10, 120);
        end else begin
            rx_mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: begin
                    m_ready <= 1'b1;
                end
                RX_COIN: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                RX_SPARSE: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= (cycle_count % 7) > 2;
                end
            endcase
        end
    end

    // Offer one sample and hold it until accepted
    task automatic send_sample(input logic enabled, input logic signed [TEMP_W-1:0] temp);
        s_valid <= 1'b1;
        s_heating_enabled <= enabled;
        s_home_temp <= temp;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        compute_valve_response(enabled, temp);
    endtask

    // Send in bursts with random gaps between them
    task automatic offer_sample(input logic enabled, input logic signed [TEMP_W-1:0] temp);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        send_sample(enabled, temp);
    endtask

    // Stop sending and wait until every expected result is in
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_valve_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Write all registers while the block is idle
    task automatic apply_settings(input cfg_t c);
        drain_results();
        write_register(CFG_TARGET_TEMP, CFG_DATA_W'(c.target_temp));
        write_register(CFG_ON_MARGIN, CFG_DATA_W'(c.on_margin));
        write_register(CFG_OFF_MARGIN, CFG_DATA_W'(c.off_margin));
        write_register(CFG_KP_GAIN, CFG_DATA_W'(c.kp_gain));
        write_register(CFG_KI_STEP_GAIN, CFG_DATA_W'(c.ki_step_gain));
        cfg_we <= 1'b0;
        settings = c;
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        c.target_temp = 16'($urandom_range(4000, 6400));
        c.on_margin = 12'($urandom_range(0, 400));
        c.off_margin = 12'($urandom_range(0, 1200));
        c.kp_gain = 16'($urandom_range(0, 4096));
        c.ki_step_gain = 16'($urandom_range(0, 1024));
        case ($urandom_range(0, 3))
            0: begin
                c.target_temp = 16'($urandom);
                c.on_margin = 12'($urandom_range(0, 4095));
                c.off_margin = 12'($urandom_range(0, 4095));
                c.kp_gain = 16'($urandom);
                c.ki_step_gain = 16'($urandom);
            end
            1: begin
                c.target_temp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                c.on_margin = $urandom_range(0, 1) ? 12'hfff : 12'h000;
                c.off_margin = $urandom_range(0, 1) ? 12'hfff : 12'h000;
                c.kp_gain = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                c.ki_step_gain = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    // Gate transitions and clamp high under the reset settings
    task automatic test_reset_state();
        send_sample(1'b1, 16'sd5000);
        send_sample(1'b1, 16'sd5200);
        send_sample(1'b1, 16'sd5377);
        send_sample(1'b1, 16'sd5300);
        send_sample(1'b1, 16'sd5170);
        send_sample(1'b0, 16'sd5170);
        send_sample(1'b1, -16'sd32768);
        send_sample(1'b1, 16'sd32767);
    endtask

    // Clamp low with a negative error, then stay on at the off edge
    task automatic test_clamp_low();
        apply_settings(cfg_t'{target_temp: 16'sd0, on_margin: 12'd100,
                              off_margin: 12'd2560, kp_gain: 16'd256,
                              ki_step_gain: 16'd77});
        send_sample(1'b1, -16'sd50);
        send_sample(1'b1, 16'sd1000);
        send_sample(1'b1, 16'sd2560);
        send_sample(1'b1, 16'sd2561);
    endtask

    // Saturated terms, margins above the usual range, and a gate that never opens
    task automatic test_extreme_settings();
        apply_settings(cfg_t'{target_temp: 16'sh7fff, on_margin: 12'hfff,
                              off_margin: 12'hfff, kp_gain: 16'hffff,
                              ki_step_gain: 16'hffff});
        send_sample(1'b1, -16'sd32768);
        send_sample(1'b1, 16'sd32767);
        send_sample(1'b1, -16'sd1);
        send_sample(1'b0, -16'sd32768);
        apply_settings(cfg_t'{target_temp: 16'sh8000, on_margin: 12'h000,
                              off_margin: 12'h000, kp_gain: 16'h0000,
                              ki_step_gain: 16'h0000});
        send_sample(1'b1, -16'sd32768);
        send_sample(1'b1, 16'sd32767);
        send_sample(1'b0, 16'sd0);
        apply_settings(cfg_t'{target_temp: 16'sh8000, on_margin: 12'hfff,
                              off_margin: 12'h000, kp_gain: 16'hffff,
                              ki_step_gain: 16'd1});
        send_sample(1'b1, -16'sd32768);
        send_sample(1'b1, -16'sd32767);
    endtask

    // Drift the temperature around the target with occasional jumps
    task automatic run_temperature_walk(input int count);
        int t;
        int target;
        int pick;
        logic en;
        logic signed [TEMP_W-1:0] raw;
        target = $signed(settings.target_temp);
        t = target;
        repeat (count) begin
            en = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                en = 1'b0;
            end else if (pick < 14) begin
                raw = 16'($urandom);
                t = raw;
            end else if (pick < 24) begin
                t = target + int'(settings.off_margin) + int'($urandom_range(1, 400));
            end else if (pick < 31) begin
                t = target - int'($urandom_range(0, 800));
            end else begin
                t = t + int'($urandom_range(0, 400)) - 200;
            end
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            offer_sample(en, 16'(t));
        end
    endtask

    task automatic test_random_settings();
        repeat (5) begin
            apply_settings(random_settings());
            run_temperature_walk(100);
        end
    endtask

    // Hold off the receiver while samples keep coming back to back
    task automatic test_backpressure();
        int t;
        apply_settings(RESET_SETTINGS);
        hold_token++;
        repeat (30) begin
            t = $signed(settings.target_temp) - int'($urandom_range(0, 300));
            send_sample(1'($urandom_range(0, 15) != 0), 16'(t));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_clamp_low();
        test_extreme_settings();
        test_random_settings();
        test_backpressure();
        drain_results();
        repeat (12) @(posedge aclk);
        if (pending_valve_results.size() != 0)
            flag_failure($sformatf("%0d expected results never arrived",
                                   pending_valve_results.size()));
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/phc_pkg.sv
hw/rtl/phc_gate.sv
hw/rtl/phc_integ.sv
hw/rtl/pi_heating_controller_hysteresis_core.sv
verif/tb_pi_heating_controller_hysteresis_core.sv
